// ----- src/drp_pkg.sv -----
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types, widths and the arctangent table for the dead-reckoning
// predictor.
// ----------------------------------------------------------------------------
package drp_pkg;

    // CORDIC datapath: Q2.30 with headroom
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INIT = 34'sh026DD3B6A;

    // Rotation datapath widths
    localparam int MUL_A_W = 16;
    localparam int DX_W    = 37;
    localparam int PROD_W  = MUL_A_W + DX_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int ROT_W   = ACC_W - 15;

    // Configuration register indexes
    localparam logic [1:0] CFG_JUMP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_MAX_GAP        = 2'd1;
    localparam logic [1:0] CFG_FALLBACK_STEP  = 2'd2;

    // Request codes
    localparam logic FUNC_INTEGRATE = 1'b0;
    localparam logic FUNC_CLEAR     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORD,
        ST_ROT,
        ST_ACCUM,
        ST_DONE
    } drp_state_t;

    typedef enum logic [2:0] {
        RS_MUL_VX,
        RS_MUL_VY,
        RS_MUL_CDX,
        RS_MUL_SDY,
        RS_MUL_SDX,
        RS_MUL_CDY,
        RS_SUM_Y,
        RS_OUT_Y
    } rot_step_t;

    // atan(2^-i) as a fraction of a full turn, 32-bit binary angle
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ----- src/dead_reckoning_predictor_top.sv -----
// ----------------------------------------------------------------------------
// dead_reckoning_predictor_top
// Planar dead reckoning: clamped time step, CORDIC yaw rotation, saturating
// nanometre accumulators and altitude jump tracking.
//
//   channel | handshake               | payload
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid / in_ready     | func, timestamp_us, yaw_angle, vel_*, alt
//   out     | out_valid / out_ready   | pos_x_nm, pos_y_nm, height_mm, flags, jump
//   cfg     | cfg_we (no wait)        | cfg_addr, cfg_wdata
//
// An integrate word passes through the one-step-per-cycle CORDIC and the
// eight-step shared multiplier before the next in_ready; a clear word skips
// both and goes from the prepare state straight to the done state.
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register, and the sequencer holds in its last state until the
// previous word is taken. Reset restores the register defaults and zeroes the
// state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dead_reckoning_predictor_top #(
    parameter int ANGLE_BITS = 16,
    parameter int POS_BITS   = 48
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [19:0]                cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic [31:0]                timestamp_us,
    input  logic signed [15:0]         yaw_angle,
    input  logic signed [15:0]         vel_x_mm_s,
    input  logic signed [15:0]         vel_y_mm_s,
    input  logic signed [15:0]         altitude_mm,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [POS_BITS-1:0] pos_x_nm,
    output logic signed [POS_BITS-1:0] pos_y_nm,
    output logic signed [15:0]         height_mm,
    output logic                       height_corrupted,
    output logic signed [16:0]         largest_jump_mm
);
    import drp_pkg::*;

    localparam int SW = ((POS_BITS > ROT_W) ? POS_BITS : ROT_W) + 1;
    localparam logic signed [SW-1:0] POS_MAX =
        {{(SW-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] POS_MIN =
        {{(SW-POS_BITS+1){1'b1}}, {(POS_BITS-1){1'b0}}};

    drp_state_t state_reg, state_next;

    // configuration
    logic [15:0] jump_thr_reg;
    logic [19:0] max_gap_reg, fallback_reg;

    // architectural state
    logic [31:0]                last_time_reg;
    logic signed [POS_BITS-1:0] x_accum_reg, y_accum_reg;
    logic signed [15:0]         height_reg;
    logic signed [16:0]         jump_reg;
    logic                       corrupt_reg;

    // captured word
    logic                func_reg;
    logic [31:0]         ts_reg;
    logic signed [15:0]  yaw_reg, vx_reg, vy_reg, alt_reg;
    logic [19:0]         dt_reg;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic signed [POS_BITS-1:0] out_x_reg, out_y_reg;
    logic signed [15:0]         out_h_reg;
    logic                       out_c_reg;
    logic signed [16:0]         out_j_reg;

    logic                in_fire, cordic_start, rot_start, load_out;
    logic                cordic_done, rot_done;
    logic signed [15:0]  cos_q15, sin_q15;
    logic signed [ROT_W-1:0] rot_x, rot_y;

    logic [31:0]         dt_raw;
    logic                dt_nonpos, dt_strange;
    logic [19:0]         dt_clamped;
    logic signed [16:0]  diff;
    logic [16:0]         mag, jmag;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [POS_BITS-1:0] sat_x, sat_y;

    drp_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .yaw     (yaw_reg),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15),
        .done    (cordic_done)
    );

    drp_rotate u_rotate (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rot_start),
        .dt      (dt_reg),
        .vel_x   (vx_reg),
        .vel_y   (vy_reg),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15),
        .rot_x   (rot_x),
        .rot_y   (rot_y),
        .done    (rot_done)
    );

    // time step: wrapped difference, strange steps clamped into 0..fallback
    assign dt_raw    = ts_reg - last_time_reg;
    assign dt_nonpos = dt_raw[31] || (dt_raw == 32'd0);
    assign dt_strange = dt_nonpos || (dt_raw > {12'b0, max_gap_reg});

    always_comb
    begin
        if (!dt_strange)
            dt_clamped = dt_raw[19:0];
        else if (dt_nonpos)
            dt_clamped = '0;
        else if (dt_raw > {12'b0, fallback_reg})
            dt_clamped = fallback_reg;
        else
            dt_clamped = dt_raw[19:0];
    end

    // altitude jump
    assign diff = {height_reg[15], height_reg} - {alt_reg[15], alt_reg};
    assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
    assign jmag = jump_reg[16] ? 17'(-jump_reg) : 17'(jump_reg);

    // saturating accumulate
    assign sum_x = {{(SW-POS_BITS){x_accum_reg[POS_BITS-1]}}, x_accum_reg}
                 + {{(SW-ROT_W){rot_x[ROT_W-1]}}, rot_x};
    assign sum_y = {{(SW-POS_BITS){y_accum_reg[POS_BITS-1]}}, y_accum_reg}
                 + {{(SW-ROT_W){rot_y[ROT_W-1]}}, rot_y};

    always_comb
    begin
        if (sum_x > POS_MAX)
            sat_x = POS_MAX[POS_BITS-1:0];
        else if (sum_x < POS_MIN)
            sat_x = POS_MIN[POS_BITS-1:0];
        else
            sat_x = sum_x[POS_BITS-1:0];
        if (sum_y > POS_MAX)
            sat_y = POS_MAX[POS_BITS-1:0];
        else if (sum_y < POS_MIN)
            sat_y = POS_MIN[POS_BITS-1:0];
        else
            sat_y = sum_y[POS_BITS-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_PREP;
            ST_PREP:  state_next = (func_reg == FUNC_CLEAR) ? ST_DONE : ST_CORD;
            ST_CORD:  if (cordic_done) state_next = ST_ROT;
            ST_ROT:   if (rot_done) state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cordic_start = 1'b0;
        rot_start    = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_PREP:  cordic_start = (func_reg == FUNC_INTEGRATE);
            ST_CORD:  rot_start = cordic_done;
            ST_DONE:  load_out = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    assign in_fire        = in_valid && in_ready;
    assign out_valid_next = load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            jump_thr_reg  <= 16'd120;
            max_gap_reg   <= 20'd50000;
            fallback_reg  <= 20'd5000;
            last_time_reg <= '0;
            x_accum_reg   <= '0;
            y_accum_reg   <= '0;
            height_reg    <= '0;
            jump_reg      <= '0;
            corrupt_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_JUMP_THRESHOLD: jump_thr_reg <= cfg_wdata[15:0];
                    CFG_MAX_GAP:        max_gap_reg  <= cfg_wdata;
                    CFG_FALLBACK_STEP:  fallback_reg <= cfg_wdata;
                    default:            ;
                endcase
            end

            if (state_reg == ST_PREP)
            begin
                if (func_reg == FUNC_CLEAR)
                begin
                    x_accum_reg <= '0;
                    y_accum_reg <= '0;
                    height_reg  <= '0;
                    jump_reg    <= '0;
                    corrupt_reg <= 1'b0;
                end
                else
                begin
                    last_time_reg <= ts_reg;
                    height_reg    <= alt_reg;
                    if (mag > {1'b0, jump_thr_reg})
                    begin
                        corrupt_reg <= 1'b1;
                        if (mag > jmag)
                            jump_reg <= diff;
                    end
                end
            end

            if (state_reg == ST_ACCUM)
            begin
                x_accum_reg <= sat_x;
                y_accum_reg <= sat_y;
            end
        end
    end

    // capture the word and the clamped step
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func;
            ts_reg   <= timestamp_us;
            yaw_reg  <= yaw_angle;
            vx_reg   <= vel_x_mm_s;
            vy_reg   <= vel_y_mm_s;
            alt_reg  <= altitude_mm;
        end
        if (state_reg == ST_PREP)
            dt_reg <= dt_clamped;
        if (load_out)
        begin
            out_x_reg <= x_accum_reg;
            out_y_reg <= y_accum_reg;
            out_h_reg <= height_reg;
            out_c_reg <= corrupt_reg;
            out_j_reg <= jump_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pos_x_nm         = out_x_reg;
    assign pos_y_nm         = out_y_reg;
    assign height_mm        = out_h_reg;
    assign height_corrupted = out_c_reg;
    assign largest_jump_mm  = out_j_reg;

    // a recorded jump always comes with the corrupted flag
    a_jump_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !corrupt_reg |-> (jump_reg == 17'sd0))
        else $error("jump recorded without corrupted flag");

    // the clamped step never exceeds both limits
    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP && func_reg == FUNC_INTEGRATE) |=>
        (dt_reg <= max_gap_reg || dt_reg <= fallback_reg))
        else $error("time step outside clamp limits");

    a_cordic_done_in_cord: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_CORD))
        else $error("CORDIC finished outside its wait state");

    a_rot_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        rot_done |-> (state_reg == ST_ROT))
        else $error("rotation finished outside its wait state");

endmodule

// ----- src/drp_cordic.sv -----
// ----------------------------------------------------------------------------
// drp_cordic
// Iterative CORDIC: one rotation step per cycle through a shared shifter,
// giving cosine and sine of the yaw angle in Q1.15.
// ----------------------------------------------------------------------------
module drp_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [15:0]  yaw,
    output logic signed [15:0]  cos_q15,
    output logic signed [15:0]  sin_q15,
    output logic                done
);
    import drp_pkg::*;

    localparam int IW = $clog2(ANGLE_BITS);

    logic signed [CORDIC_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [CORDIC_W-1:0] x_sh, y_sh, x_fin, y_fin;
    logic [31:0]                z_reg, z_next, phase, quad, angle;
    logic [IW-1:0]              iter_reg;
    logic                       flip_reg, busy_reg, fin_reg, done_reg;
    logic signed [15:0]         cos_reg, sin_reg;

    function automatic logic signed [15:0] round_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0]    t;
        logic signed [CORDIC_W-15:0] r;
        logic signed [15:0]          q;
        t = {v[CORDIC_W-1], v} + (CORDIC_W+1)'(16384);
        r = t[CORDIC_W:15];
        if (r > 32'sd32767)
            q = 16'sh7FFF;
        else if (r < -32'sd32768)
            q = 16'sh8000;
        else
            q = r[15:0];
        return q;
    endfunction

    assign phase = {yaw, 16'h0000};
    assign quad  = phase + 32'h4000_0000;
    assign x_sh  = y_reg >>> iter_reg;
    assign y_sh  = x_reg >>> iter_reg;
    assign angle = atan_turn(5'(iter_reg));

    always_comb
    begin
        if (!z_reg[31])
        begin
            x_next = x_reg - x_sh;
            y_next = y_reg + y_sh;
            z_next = z_reg - angle;
        end
        else
        begin
            x_next = x_reg + x_sh;
            y_next = y_reg - y_sh;
            z_next = z_reg + angle;
        end
    end

    // undo the half-turn pre-rotation
    assign x_fin = flip_reg ? -x_reg : x_reg;
    assign y_fin = flip_reg ? -y_reg : y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (iter_reg == IW'(ANGLE_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
                iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN_INIT;
            y_reg    <= '0;
            flip_reg <= quad[31];
            z_reg    <= quad[31] ? phase + 32'h8000_0000 : phase;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (fin_reg)
        begin
            cos_reg <= round_q15(x_fin);
            sin_reg <= round_q15(y_fin);
        end
    end

    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;
    assign done    = done_reg;

endmodule

// ----- src/drp_rotate.sv -----
// ----------------------------------------------------------------------------
// drp_rotate
// Displacement and yaw rotation on one shared registered multiplier,
// sequenced over eight steps.
// ----------------------------------------------------------------------------
module drp_rotate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [19:0]                   dt,
    input  logic signed [15:0]            vel_x,
    input  logic signed [15:0]            vel_y,
    input  logic signed [15:0]            cos_q15,
    input  logic signed [15:0]            sin_q15,
    output logic signed [drp_pkg::ROT_W-1:0] rot_x,
    output logic signed [drp_pkg::ROT_W-1:0] rot_y,
    output logic                          done
);
    import drp_pkg::*;

    localparam logic signed [ACC_W-1:0] RND = ACC_W'(16384);

    rot_step_t                 step_reg;
    logic                      busy_reg, done_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [DX_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod_c, prod_reg;
    logic signed [ACC_W-1:0]   prod_ext, acc_reg;
    logic signed [DX_W-1:0]    dx_reg, dy_reg;
    logic signed [ROT_W-1:0]   rx_reg, ry_reg;

    always_comb
    begin
        unique case (step_reg)
            RS_MUL_VX:  begin mul_a = vel_x;   mul_b = $signed({17'b0, dt}); end
            RS_MUL_VY:  begin mul_a = vel_y;   mul_b = $signed({17'b0, dt}); end
            RS_MUL_CDX: begin mul_a = cos_q15; mul_b = dx_reg;               end
            RS_MUL_SDY: begin mul_a = sin_q15; mul_b = dy_reg;               end
            RS_MUL_SDX: begin mul_a = sin_q15; mul_b = dx_reg;               end
            RS_MUL_CDY: begin mul_a = cos_q15; mul_b = dy_reg;               end
            default:    begin mul_a = '0;      mul_b = '0;                   end
        endcase
    end

    assign prod_c   = mul_a * mul_b;
    assign prod_ext = {prod_reg[PROD_W-1], prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= RS_MUL_VX;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= RS_MUL_VX;
            end
            else if (busy_reg)
            begin
                if (step_reg == RS_OUT_Y)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    step_reg <= rot_step_t'(step_reg + 3'd1);
            end
        end
    end

    // the product of each step is registered and used by the next step
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            prod_reg <= prod_c;
            case (step_reg)
                RS_MUL_VY:  dx_reg <= prod_reg[DX_W-1:0];
                RS_MUL_CDX: dy_reg <= prod_reg[DX_W-1:0];
                RS_MUL_SDY: acc_reg <= prod_ext;
                RS_MUL_SDX: acc_reg <= acc_reg + prod_ext + RND;
                RS_MUL_CDY:
                begin
                    rx_reg  <= acc_reg[ACC_W-1:15];
                    acc_reg <= -prod_ext;
                end
                RS_SUM_Y:   acc_reg <= acc_reg + prod_ext + RND;
                RS_OUT_Y:   ry_reg <= acc_reg[ACC_W-1:15];
                default:    ;
            endcase
        end
    end

    assign rot_x = rx_reg;
    assign rot_y = ry_reg;
    assign done  = done_reg;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dead_reckoning_predictor_top. IMU words go in over
// a valid/ready channel and each pose word that comes back is compared with a
// bit-exact fixed-point predictor: time-step clamping, CORDIC yaw rotation,
// saturating nanometre accumulators and altitude jump tracking. A directed
// opening is followed by random phases under several register settings and
// idling patterns, and a run at the largest step that pushes both
// accumulators outwards.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import drp_pkg::*;

    localparam int ANGLE_BITS = 16;
    localparam int POS_BITS   = 48;

    // atan(2^-i) as a fraction of a full turn
    localparam logic [31:0] ATAN_TURNS [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic [POS_BITS-1:0] x_nm;
        logic [POS_BITS-1:0] y_nm;
        logic [15:0]         height;
        logic                corrupt;
        logic [16:0]         jump;
    } pose_t;

    class pose_scoreboard;
        int     jump_limit;
        int     gap_limit;
        int     fallback;
        logic [31:0] last_ts;
        longint x_nm;
        longint y_nm;
        int     height;
        int     jump;
        bit     corrupt;
        pose_t  pending_poses [$];
        int     errors;

        function new();
            jump_limit = 120;
            gap_limit  = 50000;
            fallback   = 5000;
            last_ts    = '0;
            x_nm       = 0;
            y_nm       = 0;
            height     = 0;
            jump       = 0;
            corrupt    = 1'b0;
            errors     = 0;
        endfunction

        function int round_q15(input longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return int'(r);
        endfunction

        function void yaw_to_cos_sin(input logic [15:0] yaw, output int c, output int s);
            longint x;
            longint y;
            longint t;
            logic [31:0] z;
            logic [31:0] probe;
            bit flip;
            int i;
            x = 64'sh26DD3B6A;
            y = 0;
            z = {yaw, 16'h0000};
            // fold the back half-plane onto the front and negate at the end
            probe = z + 32'h4000_0000;
            flip = probe[31];
            if (flip)
                z = z + 32'h8000_0000;
            for (i = 0; i < ANGLE_BITS && i < 24; i++)
            begin
                if (!z[31])
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ATAN_TURNS[i];
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ATAN_TURNS[i];
                end
                x = t;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = round_q15(x);
            s = round_q15(y);
        endfunction

        function longint sat_pos(input longint acc, input longint d);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
            lo = -hi - 1;
            if (d > 0 && acc > hi - d)
                return hi;
            if (d < 0 && acc < lo - d)
                return lo;
            return acc + d;
        endfunction

        function void note_sample(input logic f, input logic [31:0] ts,
                                  input logic signed [15:0] yaw,
                                  input logic signed [15:0] vx,
                                  input logic signed [15:0] vy,
                                  input logic signed [15:0] alt);
            logic [31:0] delta;
            int     sdelta;
            longint dt;
            longint dx;
            longint dy;
            int     c;
            int     s;
            int     diff;
            int     mag;
            int     jmag;
            pose_t  want;
            if (f == FUNC_CLEAR)
            begin
                x_nm    = 0;
                y_nm    = 0;
                height  = 0;
                jump    = 0;
                corrupt = 1'b0;
            end
            else
            begin
                delta   = ts - last_ts;
                sdelta  = delta;
                dt      = sdelta;
                last_ts = ts;
                if (dt > gap_limit || dt <= 0)
                begin
                    if (dt > fallback)
                        dt = fallback;
                    if (dt < 0)
                        dt = 0;
                end
                yaw_to_cos_sin(yaw, c, s);
                dx = longint'(vx) * dt;
                dy = longint'(vy) * dt;
                x_nm = sat_pos(x_nm, (c * dx + s * dy + 16384) >>> 15);
                y_nm = sat_pos(y_nm, (-s * dx + c * dy + 16384) >>> 15);
                diff = height - int'(alt);
                mag  = (diff < 0) ? -diff : diff;
                jmag = (jump < 0) ? -jump : jump;
                if (mag > jump_limit)
                begin
                    if (mag > jmag)
                        jump = diff;
                    corrupt = 1'b1;
                end
                height = alt;
            end
            want.x_nm    = x_nm[POS_BITS-1:0];
            want.y_nm    = y_nm[POS_BITS-1:0];
            want.height  = height[15:0];
            want.corrupt = corrupt;
            want.jump    = jump[16:0];
            pending_poses.push_back(want);
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            if (errors < 100)
                $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_pose(input pose_t got);
            pose_t want;
            if (pending_poses.size() == 0)
            begin
                report_mismatch("word with no sample behind it", got.x_nm, 0);
            end
            else
            begin
                want = pending_poses.pop_front();
                if (got.x_nm !== want.x_nm)
                    report_mismatch("pos_x_nm", got.x_nm, want.x_nm);
                if (got.y_nm !== want.y_nm)
                    report_mismatch("pos_y_nm", got.y_nm, want.y_nm);
                if (got.height !== want.height)
                    report_mismatch("height_mm", got.height, want.height);
                if (got.corrupt !== want.corrupt)
                    report_mismatch("height_corrupted", got.corrupt, want.corrupt);
                if (got.jump !== want.jump)
                    report_mismatch("largest_jump_mm", got.jump, want.jump);
            end
        endtask

        task flush_leftovers();
            if (pending_poses.size() != 0)
                report_mismatch("words never delivered", pending_poses.size(), 0);
        endtask
    endclass

    logic                       clk              = 1'b0;
    logic                       rst_n            = 1'b0;
    logic                       cfg_we           = 1'b0;
    logic [1:0]                 cfg_addr         = '0;
    logic [19:0]                cfg_wdata        = '0;
    logic                       in_valid         = 1'b0;
    logic                       in_ready;
    logic                       func             = FUNC_INTEGRATE;
    logic [31:0]                timestamp_us     = '0;
    logic signed [15:0]         yaw_angle        = '0;
    logic signed [15:0]         vel_x_mm_s       = '0;
    logic signed [15:0]         vel_y_mm_s       = '0;
    logic signed [15:0]         altitude_mm      = '0;
    logic                       out_valid;
    logic                       out_ready        = 1'b0;
    logic signed [POS_BITS-1:0] pos_x_nm;
    logic signed [POS_BITS-1:0] pos_y_nm;
    logic signed [15:0]         height_mm;
    logic                       height_corrupted;
    logic signed [16:0]         largest_jump_mm;

    pose_scoreboard sb;
    pose_t          seen;
    int             snd_idle = 14;
    int             rcv_idle = 72;

    // register settings per random phase: threshold, max gap, fallback step
    int limit_thr [7] = '{0, 65535, 120, 30, 500, 1, 200};
    int limit_gap [7] = '{1, 1048575, 0, 2000, 50000, 1048575, 300};
    int limit_fb  [7] = '{0, 1048575, 5000, 1048575, 5000, 0, 100000};

    logic signed [15:0] yaw_marks [8] = '{16'sh0000, 16'sh3FFF, 16'sh4000, 16'shC000,
                                         16'shBFFF, 16'sh8000, 16'sh7FFF, 16'sh2000};
    logic signed [15:0] vel_marks [3] = '{16'sh8000, 16'sh7FFF, 16'sh0000};

    dead_reckoning_predictor_top #(
        .ANGLE_BITS (ANGLE_BITS),
        .POS_BITS   (POS_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .timestamp_us     (timestamp_us),
        .yaw_angle        (yaw_angle),
        .vel_x_mm_s       (vel_x_mm_s),
        .vel_y_mm_s       (vel_y_mm_s),
        .altitude_mm      (altitude_mm),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pos_x_nm         (pos_x_nm),
        .pos_y_nm         (pos_y_nm),
        .height_mm        (height_mm),
        .height_corrupted (height_corrupted),
        .largest_jump_mm  (largest_jump_mm)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            seen.x_nm    = pos_x_nm;
            seen.y_nm    = pos_y_nm;
            seen.height  = height_mm;
            seen.corrupt = height_corrupted;
            seen.jump    = largest_jump_mm;
            sb.check_pose(seen);
        end
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    task automatic send_word(input logic f, input logic [31:0] ts,
                             input logic signed [15:0] yaw,
                             input logic signed [15:0] vx,
                             input logic signed [15:0] vy,
                             input logic signed [15:0] alt);
        if ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 48)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        timestamp_us <= ts;
        yaw_angle    <= yaw;
        vel_x_mm_s   <= vx;
        vel_y_mm_s   <= vy;
        altitude_mm  <= alt;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(f, ts, yaw, vx, vy, alt);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_poses.size() != 0) @(posedge clk);
    endtask

    task automatic write_limits(input int thr, input int gap, input int fb);
        wait_drained();
        // let the sequencer fall back to idle before touching the registers
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_JUMP_THRESHOLD;
        cfg_wdata <= 20'(thr);
        @(posedge clk);
        cfg_addr  <= CFG_MAX_GAP;
        cfg_wdata <= 20'(gap);
        @(posedge clk);
        cfg_addr  <= CFG_FALLBACK_STEP;
        cfg_wdata <= 20'(fb);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.jump_limit = thr & 32'hFFFF;
        sb.gap_limit  = gap;
        sb.fallback   = fb;
        @(posedge clk);
    endtask

    task automatic random_word();
        logic               f;
        logic [31:0]        ts;
        logic signed [15:0] yaw;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] alt;
        int span;
        int pick;
        int d;
        f = ($urandom_range(0, 99) < 4) ? FUNC_CLEAR : FUNC_INTEGRATE;
        span = (sb.gap_limit > 0) ? sb.gap_limit : 1000;
        pick = $urandom_range(0, 99);
        if (pick < 66)
            ts = sb.last_ts + $urandom_range(1, span);
        else if (pick < 73)
            ts = sb.last_ts;
        else if (pick < 80)
            ts = sb.last_ts + span + $urandom_range(1, 2000000);
        else if (pick < 87)
            ts = sb.last_ts - $urandom_range(1, 100000);
        else if (pick < 92)
            ts = sb.last_ts + sb.gap_limit + $urandom_range(0, 1);
        else if (pick < 94)
            ts = sb.last_ts + 32'h8000_0000 - $urandom_range(0, 1);
        else
            ts = $urandom;

        yaw = ($urandom_range(0, 99) < 85) ? 16'($urandom) : yaw_marks[$urandom_range(0, 7)];
        vx  = ($urandom_range(0, 99) < 80) ? 16'($urandom) : vel_marks[$urandom_range(0, 2)];
        vy  = ($urandom_range(0, 99) < 80) ? 16'($urandom) : vel_marks[$urandom_range(0, 2)];

        // keep the altitude moving around the jump threshold
        pick = $urandom_range(0, 99);
        if (pick < 35)
            d = sb.jump_limit + $urandom_range(0, 2) - 1;
        else if (pick < 50)
            d = (sb.jump < 0) ? -sb.jump : sb.jump;
        else if (pick < 80)
            d = $urandom_range(0, 100) - 50;
        else
            d = $urandom;
        if ($urandom_range(0, 1))
            d = -d;
        alt = 16'(sb.height + d);
        send_word(f, ts, yaw, vx, vy, alt);
    endtask

    task automatic directed_words();
        send_word(FUNC_INTEGRATE, 32'd1000, 16'sd0, 16'sd1000, 16'sd0, 16'sd0);
        send_word(FUNC_INTEGRATE, 32'd51000, 16'sd16384, 16'sd32767, -16'sd32768, 16'sd121);
        send_word(FUNC_INTEGRATE, 32'd101001, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd1);
        send_word(FUNC_INTEGRATE, 32'd101001, 16'sd32767, 16'sd12345, -16'sd12345, -16'sd32768);
        send_word(FUNC_INTEGRATE, 32'd1001, -16'sd16384, 16'sd32767, 16'sd32767, 16'sd32767);
        send_word(FUNC_INTEGRATE, 32'h8000_03E8, 16'sd16383, -16'sd32768, -16'sd32768,
                  -16'sd32768);
        send_word(FUNC_INTEGRATE, 32'd1000, -16'sd16385, 16'sd0, 16'sd32767, 16'sd0);
        send_word(FUNC_CLEAR, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        send_word(FUNC_INTEGRATE, 32'hFFFF_FF00, 16'sd8192, 16'sd20000, 16'sd10000, 16'sd50);
        send_word(FUNC_INTEGRATE, 32'h0000_0100, -16'sd8192, -16'sd20000, 16'sd30000, 16'sd170);
        send_word(FUNC_INTEGRATE, 32'h0000_62A8, 16'sd24576, 16'sd32767, 16'sd0, 16'sd291);
        send_word(FUNC_INTEGRATE, 32'h0000_62AA, -16'sd24576, -16'sd7, 16'sd9, 16'sd170);
        send_word(FUNC_CLEAR, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        send_word(FUNC_INTEGRATE, 32'h0000_62B4, 16'sd4096, 16'sd3000, -16'sd3000, -16'sd500);
        send_word(FUNC_INTEGRATE, 32'hFFFF_FFFF, -16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_word(FUNC_INTEGRATE, 32'h0000_0000, 16'sd1, 16'sd1, -16'sd1, 16'sd0);
        send_word(FUNC_INTEGRATE, 32'h1000_0000, 16'sd12000, -16'sd32768, -16'sd32768, 16'sd100);
    endtask

    // push x towards its upper limit and y towards its lower one at the largest step
    task automatic saturation_run();
        int k;
        send_word(FUNC_CLEAR, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        for (k = 0; k < 100; k++)
        begin
            send_word(FUNC_INTEGRATE, sb.last_ts + 32'd1048575,
                      16'($urandom_range(0, 64) - 32),
                      16'sd32767 - 16'($urandom_range(0, 7)),
                      -16'sd32768 + 16'($urandom_range(0, 7)),
                      16'($urandom_range(0, 200) - 100));
        end
        for (k = 0; k < 20; k++)
            random_word();
    endtask

    initial
    begin
        int ph;
        int n;
        int k;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        for (ph = 0; ph < 7; ph++)
        begin
            if (ph == 3)
            begin
                snd_idle = 72;
                rcv_idle = 14;
            end
            if (ph == 5)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_limits(limit_thr[ph], limit_gap[ph], limit_fb[ph]);
            for (n = 0; n < 80; n++)
            begin
                random_word();
                // hold off until the pipeline is empty
                if (n == 60 && ph % 2 == 0)
                    wait_drained();
            end
        end

        write_limits(65535, 1048575, 1048575);
        saturation_run();

        in_valid <= 1'b0;
        for (k = 0; k < 5000 && sb.pending_poses.size() != 0; k++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        sb.flush_leftovers();
        if (sb.errors == 0)
            $display("dead_reckoning_predictor_top test passed");
        else
            $display("dead_reckoning_predictor_top test failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("dead_reckoning_predictor_top test failed");
        $finish;
    end

endmodule

// ----- dead_reckoning_predictor_top.f -----
src/drp_pkg.sv
src/drp_cordic.sv
src/drp_rotate.sv
src/dead_reckoning_predictor_top.sv
test/testbench.sv
